/* sv/pfa_pkg.sv */
// shared constants, codes and types for the page frame allocator
package pfa_pkg;

  localparam int PAGE_SHIFT       = 12;
  localparam int FREE_STACK_DEPTH = 1024;

  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 31;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 2;

  localparam logic [ADDR_W-1:0]  PAGE_BYTES    = ADDR_W'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0]  PAGE_LOW_MASK = PAGE_BYTES - ADDR_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_PAGES  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL_FREE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESTART_REJ   = 3'd4;

  // configuration register indexes
  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [ADDR_W-1:0] data;
  } stk_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] top;
  } stk_stat_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_count;
  } result_t;

endpackage

/* sv/page_frame_allocator_core.sv */
// top level of the page frame allocator: config registers, input and result registers
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------------------
//  s        | in  | s_tvalid/s_tready | s_tdata: operation, page_address
//  m        | out | m_tvalid/m_tready | m_tdata: granted_address, status, free/total
//  cfg      | in  | cfg_we            | cfg_index, cfg_data (region_start, region_end)
//
// one word per cycle sustained while m_tready is high: input register -> engine ->
// result register, with the engine output registered in the result register; stack top and
// next entry are registers, so pops and pushes run in consecutive cycles
// rst clears counts, bump pointers, stack depth and the config registers; the stack
// memory is never cleared (entries above the depth are never read)
// a stalled result holds the input register; it takes a word while empty or draining
module page_frame_allocator_core #(
  parameter int FREE_STACK_DEPTH = pfa_pkg::FREE_STACK_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // operation[1:0], page_address[65:2], zero pad
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // granted_address[63:0], status[66:64],
                                  // free_count[97:67], total_count[128:98], zero pad
  // config write port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);

  // config registers
  logic [pfa_pkg::ADDR_W-1:0] region_start;
  logic [pfa_pkg::ADDR_W-1:0] region_end;

  // input register
  logic                       in_valid;
  logic [pfa_pkg::OP_W-1:0]   in_op;
  logic [pfa_pkg::ADDR_W-1:0] in_addr;

  // result register
  logic                       out_valid;
  pfa_pkg::result_t           out_res;

  logic                       advance;
  pfa_pkg::stk_cmd_t          stk_cmd;
  pfa_pkg::stk_stat_t         stk_stat;
  pfa_pkg::result_t           eng_res;

  // a held word moves on when the result register is free or being taken
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfa_pkg::CFG_REGION_START: region_start <= cfg_data;
        pfa_pkg::CFG_REGION_END:   region_end   <= cfg_data;
        default:                   region_end   <= region_end;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tdata[1:0];
      in_addr <= s_tdata[65:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eng_res;
    end
  end

  pfa_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .op           (in_op),
    .page_address (in_addr),
    .region_start (region_start),
    .region_end   (region_end),
    .stat         (stk_stat),
    .cmd          (stk_cmd),
    .res          (eng_res)
  );

  pfa_stack #(
    .FREE_STACK_DEPTH (FREE_STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0,
                     out_res.total_count,
                     out_res.free_count,
                     out_res.status,
                     out_res.granted_address};

`ifndef ASSERT_OFF
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed word did not reach the result register");
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.granted_address != '0 |-> out_res.status == pfa_pkg::ST_OK)
    else $error("nonzero grant with error status");
  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == pfa_pkg::ST_OUT_OF_PAGES |->
      out_res.granted_address == '0)
    else $error("out of pages with nonzero address");
`endif

endmodule

/* sv/pfa_stack.sv */
// free page stack: memory below a registered top entry and a registered next-below entry
module pfa_stack #(
  parameter int FREE_STACK_DEPTH = pfa_pkg::FREE_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  pfa_pkg::stk_cmd_t  cmd,
  output pfa_pkg::stk_stat_t stat
);

  localparam int AW = (FREE_STACK_DEPTH > 1) ? $clog2(FREE_STACK_DEPTH) : 1;
  localparam int DW = $clog2(FREE_STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(FREE_STACK_DEPTH);

  logic [pfa_pkg::ADDR_W-1:0] mem [FREE_STACK_DEPTH];

  logic [DW-1:0]              depth;
  logic [DW-1:0]              rd_depth;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [pfa_pkg::ADDR_W-1:0] top_word;
  logic [pfa_pkg::ADDR_W-1:0] below_rd;
  logic [pfa_pkg::ADDR_W-1:0] below_byp;
  logic [pfa_pkg::ADDR_W-1:0] below_word;
  logic                       below_sel_byp;

  // top lives in top_word, entry depth-2 in below_word, memory holds the rest
  assign wr_addr    = depth[AW-1:0];
  assign rd_depth   = depth - DW'(3);
  assign rd_addr    = rd_depth[AW-1:0];
  assign below_word = below_sel_byp ? below_byp : below_rd;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.data;
    end
    if (cmd.pop) begin
      below_rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_word  <= cmd.data;
      below_byp <= top_word;
    end else if (cmd.pop) begin
      top_word <= below_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth         <= '0;
      below_sel_byp <= 1'b0;
    end else if (cmd.clear) begin
      depth         <= '0;
    end else if (cmd.push) begin
      depth         <= depth + DW'(1);
      below_sel_byp <= 1'b1;
    end else if (cmd.pop) begin
      depth         <= depth - DW'(1);
      below_sel_byp <= 1'b0;
    end
  end

  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DEPTH_FULL);
  assign stat.top   = top_word;

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into full free stack");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty free stack");
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !cmd.clear |=> !stat.empty && stat.top == $past(cmd.data))
    else $error("pushed word not on top of stack");
`endif

endmodule

/* sv/pfa_engine.sv */
// allocator state and single pass decision logic for one request
module pfa_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [pfa_pkg::OP_W-1:0]      op,
  input  logic [pfa_pkg::ADDR_W-1:0]    page_address,
  input  logic [pfa_pkg::ADDR_W-1:0]    region_start,
  input  logic [pfa_pkg::ADDR_W-1:0]    region_end,
  input  pfa_pkg::stk_stat_t            stat,
  output pfa_pkg::stk_cmd_t             cmd,
  output pfa_pkg::result_t              res
);

  logic [pfa_pkg::ADDR_W-1:0]  bump_next;
  logic [pfa_pkg::ADDR_W-1:0]  bump_limit;
  logic [pfa_pkg::COUNT_W-1:0] pages_free;
  logic [pfa_pkg::COUNT_W-1:0] pages_total;

  logic [pfa_pkg::ADDR_W-1:0]  bump_next_next;
  logic [pfa_pkg::ADDR_W-1:0]  bump_limit_next;
  logic [pfa_pkg::COUNT_W-1:0] pages_free_next;
  logic [pfa_pkg::COUNT_W-1:0] pages_total_next;

  logic [pfa_pkg::ADDR_W:0]    lo_sum;
  logic [pfa_pkg::ADDR_W-1:0]  lo;
  logic [pfa_pkg::ADDR_W-1:0]  hi;
  logic [pfa_pkg::ADDR_W-1:0]  span;
  logic [pfa_pkg::ADDR_W-1:0]  pages;
  logic [pfa_pkg::COUNT_W-1:0] pages_sat;
  logic                        restart_reject;
  logic                        bump_ok;
  logic [pfa_pkg::COUNT_W-1:0] free_dec;
  logic [pfa_pkg::COUNT_W-1:0] free_inc;
  logic                        push;
  logic                        pop;
  logic                        clear;

  // region rounding and page count
  assign lo_sum = {1'b0, region_start} + {1'b0, pfa_pkg::PAGE_LOW_MASK};
  assign lo     = lo_sum[pfa_pkg::ADDR_W-1:0] & ~pfa_pkg::PAGE_LOW_MASK;
  assign hi     = region_end & ~pfa_pkg::PAGE_LOW_MASK;
  assign span   = hi - lo;
  assign pages  = span >> pfa_pkg::PAGE_SHIFT;
  assign pages_sat = (|pages[pfa_pkg::ADDR_W-1:pfa_pkg::COUNT_W]) ? pfa_pkg::COUNT_MAX
                                                                  : pages[pfa_pkg::COUNT_W-1:0];
  assign restart_reject = lo_sum[pfa_pkg::ADDR_W] || (hi <= lo);

  assign bump_ok = (bump_next <= bump_limit) &&
                   ((bump_limit - bump_next) >= pfa_pkg::PAGE_BYTES);

  assign free_dec = (pages_free != '0) ? pages_free - pfa_pkg::COUNT_W'(1) : pages_free;
  assign free_inc = (pages_free != pfa_pkg::COUNT_MAX) ? pages_free + pfa_pkg::COUNT_W'(1)
                                                       : pages_free;

  always_comb begin
    bump_next_next   = bump_next;
    bump_limit_next  = bump_limit;
    pages_free_next  = pages_free;
    pages_total_next = pages_total;
    push             = 1'b0;
    pop              = 1'b0;
    clear            = 1'b0;
    res.granted_address = '0;
    res.status          = pfa_pkg::ST_OK;
    unique case (op)
      pfa_pkg::OP_RESTART: begin
        if (restart_reject) begin
          res.status = pfa_pkg::ST_RESTART_REJ;
        end else begin
          bump_next_next   = lo;
          bump_limit_next  = hi;
          pages_total_next = pages_sat;
          pages_free_next  = pages_sat;
          clear            = 1'b1;
        end
      end
      pfa_pkg::OP_ALLOC: begin
        priority if (!stat.empty) begin
          pop                 = 1'b1;
          res.granted_address = stat.top;
          pages_free_next     = free_dec;
        end else if (bump_ok) begin
          res.granted_address = bump_next;
          bump_next_next      = bump_next + pfa_pkg::PAGE_BYTES;
          pages_free_next     = free_dec;
        end else begin
          res.status = pfa_pkg::ST_OUT_OF_PAGES;
        end
      end
      pfa_pkg::OP_FREE: begin
        priority if (page_address == '0) begin
          res.status = pfa_pkg::ST_NULL_FREE;
        end else if (stat.full) begin
          res.status = pfa_pkg::ST_STACK_FULL;
        end else begin
          push            = 1'b1;
          pages_free_next = free_inc;
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
    res.free_count  = pages_free_next;
    res.total_count = pages_total_next;
  end

  assign cmd.push  = fire && push;
  assign cmd.pop   = fire && pop;
  assign cmd.clear = fire && clear;
  assign cmd.data  = page_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_next   <= '0;
      bump_limit  <= '0;
      pages_free  <= '0;
      pages_total <= '0;
    end else if (fire) begin
      bump_next   <= bump_next_next;
      bump_limit  <= bump_limit_next;
      pages_free  <= pages_free_next;
      pages_total <= pages_total_next;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench for page_frame_allocator_core: stream driver, result monitor and in-line allocator model
module tb_top;
  import pfa_pkg::*;

  // clock, reset and block ports; every input starts from a known value
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;     // operation[1:0], page_address[65:2], zero pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;          // granted_address[63:0], status[66:64],
                                  // free_count[97:67], total_count[128:98], zero pad
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [63:0]  cfg_data = '0;

  always #10 clk = ~clk;

  page_frame_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // stimulus plan: words, register writes and drain points, filled up front
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {DO_WORD, DO_CFG, DO_DRAIN} step_kind_t;

  // operation code with no meaning: changes nothing, ok status
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  op;
    logic [63:0] addr;
    logic        cfg_sel;
    logic [63:0] cfg_val;
    int          gap;
  } plan_step_t;

  plan_step_t plan_q[$];
  bit         gap_mode = 1'b1;    // sender inserts idle cycles while set

  // ---------------------------------------------------------------------------
  // allocator model: own copy of the registers, bump pointer, free stack, counts
  // ---------------------------------------------------------------------------
  logic [63:0]        cfg_start = '0;
  logic [63:0]        cfg_end = '0;
  logic [63:0]        bump_ptr = '0;
  logic [63:0]        bump_end = '0;
  logic [63:0]        freed_stack [FREE_STACK_DEPTH];
  int                 stack_used = 0;
  logic [COUNT_W-1:0] model_free = '0;
  logic [COUNT_W-1:0] model_total = '0;

  result_t pending_results[$];    // expected result words, oldest first
  int      mismatches = 0;
  int      words_sent = 0;        // accepted on the input side
  int      results_seen = 0;      // accepted on the output side

  task automatic step_allocator(input logic [1:0] op, input logic [63:0] addr,
                                output result_t res);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] pages;
    res.granted_address = '0;
    res.status = ST_OK;
    case (op)
      OP_RESTART: begin
        lo = cfg_start + PAGE_LOW_MASK;
        hi = cfg_end & ~PAGE_LOW_MASK;
        // rounding the start up past the top of the address space
        if (lo < cfg_start) begin
          res.status = ST_RESTART_REJ;
        end else begin
          lo = lo & ~PAGE_LOW_MASK;
          // empty region leaves everything as it was
          if (hi <= lo) begin
            res.status = ST_RESTART_REJ;
          end else begin
            bump_ptr = lo;
            bump_end = hi;
            pages = (hi - lo) >> PAGE_SHIFT;
            model_total = (pages > 64'(COUNT_MAX)) ? COUNT_MAX : pages[COUNT_W-1:0];
            model_free = model_total;
            stack_used = 0;
          end
        end
      end
      OP_ALLOC: begin
        if (stack_used > 0) begin
          stack_used--;
          res.granted_address = freed_stack[stack_used];
        end else if (bump_ptr <= bump_end && bump_end - bump_ptr >= PAGE_BYTES) begin
          res.granted_address = bump_ptr;
          bump_ptr = bump_ptr + PAGE_BYTES;
        end else begin
          res.status = ST_OUT_OF_PAGES;
        end
        if (res.status == ST_OK && model_free != '0) model_free = model_free - 1'b1;
      end
      OP_FREE: begin
        if (addr == '0) begin
          res.status = ST_NULL_FREE;
        end else if (stack_used >= FREE_STACK_DEPTH) begin
          res.status = ST_STACK_FULL;
        end else begin
          freed_stack[stack_used] = addr;
          stack_used++;
          if (model_free < COUNT_MAX) model_free = model_free + 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.free_count = model_free;
    res.total_count = model_total;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %0s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // idle run length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one decision per edge, each signal assigned once
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int settle = 0;

  always @(posedge clk) begin
    result_t res;
    logic    nxt_valid;
    logic    nxt_we;
    logic    took;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we <= 1'b0;
      gap_left = 0;
      settle = 0;
    end else begin
      took = s_tvalid && s_tready;
      // a word taken at this edge is predicted now, in acceptance order
      if (took) begin
        step_allocator(s_tdata[1:0], s_tdata[65:2], res);
        pending_results.push_back(res);
        words_sent <= words_sent + 1;
      end
      nxt_valid = s_tvalid && !s_tready;
      nxt_we = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plan_q.size() > 0) begin
          case (plan_q[0].kind)
            DO_WORD: begin
              s_tdata <= {6'b0, plan_q[0].addr, plan_q[0].op};
              nxt_valid = 1'b1;
              gap_left = plan_q[0].gap;
              void'(plan_q.pop_front());
            end
            DO_CFG: begin
              nxt_we = 1'b1;
              cfg_index <= plan_q[0].cfg_sel;
              cfg_data <= plan_q[0].cfg_val;
              if (plan_q[0].cfg_sel == CFG_REGION_START) cfg_start = plan_q[0].cfg_val;
              else cfg_end = plan_q[0].cfg_val;
              void'(plan_q.pop_front());
            end
            default: begin
              // drain point: every result back, then a few quiet cycles
              if (!took && words_sent == results_seen) begin
                if (settle >= 4) begin
                  settle = 0;
                  void'(plan_q.pop_front());
                end else begin
                  settle++;
                end
              end else begin
                settle = 0;
              end
            end
          endcase
        end
      end
      s_tvalid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with random back-pressure
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_mode = 1'b1;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing pending", m_tdata[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[63:0] !== want.granted_address)
            flag_mismatch("granted_address", m_tdata[63:0], want.granted_address);
          if (m_tdata[66:64] !== want.status)
            flag_mismatch("status", 64'(m_tdata[66:64]), 64'(want.status));
          if (m_tdata[97:67] !== want.free_count)
            flag_mismatch("free_count", 64'(m_tdata[97:67]), 64'(want.free_count));
          if (m_tdata[128:98] !== want.total_count)
            flag_mismatch("total_count", 64'(m_tdata[128:98]), 64'(want.total_count));
        end
      end
      // stretches with and without stalls alternate now and then
      if ($urandom_range(0, 299) == 0) stall_mode = !stall_mode;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (stall_mode && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // plan building helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(input logic [1:0] op, input logic [63:0] addr);
    plan_step_t s;
    s.kind = DO_WORD;
    s.op = op;
    s.addr = addr;
    s.cfg_sel = 1'b0;
    s.cfg_val = '0;
    s.gap = (gap_mode && $urandom_range(0, 99) >= 60) ? pick_gap() : 0;
    plan_q.push_back(s);
  endtask

  task automatic add_pause();
    plan_step_t s;
    s.kind = DO_DRAIN;
    s.op = OP_RESTART;
    s.addr = '0;
    s.cfg_sel = 1'b0;
    s.cfg_val = '0;
    s.gap = 0;
    plan_q.push_back(s);
  endtask

  // registers only change once the block has gone quiet
  task automatic add_config(input logic sel, input logic [63:0] val);
    plan_step_t s;
    add_pause();
    s.kind = DO_CFG;
    s.op = OP_RESTART;
    s.addr = '0;
    s.cfg_sel = sel;
    s.cfg_val = val;
    s.gap = 0;
    plan_q.push_back(s);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // page-aligned base used to aim freed addresses into the current region
  function automatic logic [63:0] cfg_region_floor(input logic [63:0] a);
    return a & ~PAGE_LOW_MASK;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence: directed corners, full stack, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] base;
    logic [63:0] lim;
    int          r;
    int          n;

    // nothing set up yet: out of pages, null free, free and reuse, empty region
    add_word(OP_ALLOC, '0);
    add_word(OP_FREE, '0);
    add_word(OP_FREE, '1);
    add_word(OP_ALLOC, '0);
    add_word(OP_RESTART, '0);

    // three pages starting at address zero, with an unaligned end
    add_config(CFG_REGION_START, '0);
    add_config(CFG_REGION_END, 64'h3005);
    add_word(OP_RESTART, '0);
    repeat (4) add_word(OP_ALLOC, '0);
    add_word(OP_FREE, 64'h1234);       // unaligned page goes back as given
    add_word(OP_UNUSED, 64'h7000);     // unused code leaves the state alone
    add_word(OP_ALLOC, '0);

    // rounding the start up overflows, so the restart is refused
    add_config(CFG_REGION_START, '1);
    add_config(CFG_REGION_END, '1);
    add_word(OP_RESTART, '0);
    add_word(OP_ALLOC, '0);

    // whole address space: counts saturate
    add_config(CFG_REGION_START, 64'h1);
    add_word(OP_RESTART, '0);
    add_word(OP_ALLOC, '0);
    add_word(OP_FREE, 64'h5000);
    add_word(OP_ALLOC, '0);

    // rounded start meets rounded end, then a single page at the very top
    add_config(CFG_REGION_START, 64'hFFFF_FFFF_FFFF_E001);
    add_word(OP_RESTART, '0);
    add_config(CFG_REGION_START, 64'hFFFF_FFFF_FFFF_E000);
    add_word(OP_RESTART, '0);
    add_word(OP_ALLOC, '0);
    add_word(OP_ALLOC, '0);

    // fill the free stack past its depth, back to back for the first half
    add_config(CFG_REGION_START, 64'h1000_0000);
    add_config(CFG_REGION_END, 64'h1000_8000);
    add_word(OP_RESTART, '0);
    gap_mode = 1'b0;
    for (int i = 0; i < FREE_STACK_DEPTH + 8; i++) begin
      if (i == FREE_STACK_DEPTH / 2) gap_mode = 1'b1;
      add_word(OP_FREE, rand64() | 64'h1000);
    end
    add_word(OP_FREE, '0);
    repeat (4) add_word(OP_ALLOC, '0);
    add_word(OP_FREE, rand64() | 64'h1);

    // random phases: new region, restart, then a mix of alloc and free
    for (int ph = 0; ph < 4; ph++) begin
      gap_mode = (ph % 4 != 1);
      r = $urandom_range(0, 9);
      if (r < 6) begin
        base = {$urandom_range(0, 32'hFFFF_FFFE), $urandom()};
        lim = base + 64'($urandom_range(0, 48)) * PAGE_BYTES + 64'($urandom_range(0, 4095));
      end else if (r == 6) begin
        lim = rand64();
        base = lim + 64'($urandom_range(0, 8000));
      end else if (r == 7) begin
        base = 64'($urandom_range(0, 4095));
        lim = 64'($urandom_range(0, 40)) * PAGE_BYTES + 64'($urandom_range(0, 4095));
      end else if (r == 8) begin
        base = 64'($urandom_range(0, 1 << 20));
        lim = rand64() | {1'b1, 63'd0};
      end else begin
        base = 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(1, 4095));
        lim = rand64();
      end
      if (ph < 2 || $urandom_range(0, 3) != 0) add_config(CFG_REGION_START, base);
      add_config(CFG_REGION_END, lim);
      add_word(OP_RESTART, '0);
      base = cfg_region_floor(base);
      n = 0;
      while (n < 32) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          add_word(OP_ALLOC, '0);
          n++;
        end else if (r < 90) begin
          r = $urandom_range(0, 99);
          if (r < 10) add_word(OP_FREE, '0);
          else if (r < 30) add_word(OP_FREE, rand64());
          else add_word(OP_FREE, base + (64'($urandom_range(0, 63)) << PAGE_SHIFT));
          n++;
        end else if (r < 95) begin
          add_word(OP_RESTART, '0);
          n++;
        end else begin
          // hold off until every outstanding result is back
          add_pause();
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all words handed over, then all results back, then a short tail
    while (plan_q.size() != 0 || s_tvalid) @(negedge clk);
    while (words_sent != results_seen) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never arrived", 64'(pending_results.size()), '0);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
sv/pfa_pkg.sv
sv/pfa_stack.sv
sv/pfa_engine.sv
sv/page_frame_allocator_core.sv
tb/sv/tb_top.sv
